@@ src/hbs_pkg.sv @@
// Shared types and constants of the heightfield bilinear sampler.
// No dependencies; hbs_fifo, hbs_front, hbs_back and the top level import this package.
package hbs_pkg;

    localparam int COORD_W     = 25;   // clamped grid-mapping numerator, [0, 2T]
    localparam int HEIGHT_W    = 24;
    localparam int INDEX_W     = 16;
    localparam int SIZE_W      = 24;
    localparam int RES_W       = 9;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [SIZE_W-1:0] SIZE_ONE  = 24'd256;
    localparam logic [SIZE_W-1:0] SIZE_RST  = 24'd256;
    localparam logic [RES_W-1:0]  RES_RST   = 9'd2;
    localparam logic [RES_W-1:0]  RES_MIN   = 9'd2;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic REG_TERRAIN_SIZE = 1'b0;
    localparam logic REG_GRID_RES     = 1'b1;

    typedef struct packed {
        logic [SIZE_W-1:0]  t;        // terrain size, at least 1.0
        logic [COORD_W-1:0] twice_t;
        logic               res_low;  // resolution below two: answer zero
    } cfg_t;

    typedef struct packed {
        logic                       func;
        logic [INDEX_W-1:0]         idx;
        logic signed [HEIGHT_W-1:0] wh;
        logic [COORD_W-1:0]         a;
        logic [COORD_W-1:0]         c;
    } item_t;

    typedef struct packed {
        logic                       valid;
        logic                       func;
        logic [INDEX_W-1:0]         idx;
        logic signed [HEIGHT_W-1:0] wh;
    } meta_t;

endpackage

@@ src/hbs_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module hbs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/hbs_fifo.sv @@
// Short item queue between the front and back of the sampler.
// Depends on hbs_pkg for item_t and the queue depth.
module hbs_fifo import hbs_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t head_item,
    output logic  full,
    output logic  empty
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    assign full      = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (cnt_reg == '0);
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ src/hbs_front.sv @@
// Front end: accept items, tag write or sample, map world X,Z onto clamped
// terrain numerators. Depends on hbs_pkg.
module hbs_front import hbs_pkg::*; (
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_func,
    input  logic [INDEX_W-1:0]         s_write_index,
    input  logic signed [HEIGHT_W-1:0] s_write_height,
    input  logic signed [HEIGHT_W-1:0] s_world_x,
    input  logic signed [HEIGHT_W-1:0] s_world_z,
    input  cfg_t                       cfg,
    input  logic                       fifo_full,
    output logic                       push,
    output item_t                      push_item
);

    function automatic logic [COORD_W-1:0] clamp_coord(
        input logic signed [COORD_W:0] v,
        input logic [COORD_W-1:0]      lim
    );
        logic signed [COORD_W:0] lim_s;
        lim_s = {1'b0, lim};
        if (v <= 0) begin
            return '0;
        end else if (v >= lim_s) begin
            return lim;
        end else begin
            return v[COORD_W-1:0];
        end
    endfunction

    logic signed [COORD_W:0] wx2, wz2, ts, sa, sc;

    always_comb begin
        wx2 = {s_world_x[HEIGHT_W-1], s_world_x, 1'b0};
        wz2 = {s_world_z[HEIGHT_W-1], s_world_z, 1'b0};
        ts  = {2'b00, cfg.t};
        sa  = wx2 + ts;
        sc  = ts - wz2;

        push_item.func = s_func;
        push_item.idx  = s_write_index;
        push_item.wh   = s_write_height;
        push_item.a    = clamp_coord(sa, cfg.twice_t);
        push_item.c    = clamp_coord(sc, cfg.twice_t);
    end

    assign s_ready = !fifo_full;
    assign push    = s_valid && !fifo_full;

endmodule

@@ src/hbs_back.sv @@
// Back end: grid scaling by a pipelined divider, store access on four
// replicated height RAMs, bilinear blend, output register.
// Depends on hbs_pkg and hbs_ram.
module hbs_back import hbs_pkg::*; #(
    parameter int GRID_MAX = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  cfg_t                              cfg,
    input  logic [$clog2(GRID_MAX+1)-1:0]     n,
    input  logic [$clog2(GRID_MAX)-1:0]       nm1,
    input  logic                              fifo_empty,
    input  item_t                             fifo_item,
    output logic                              fifo_pop,
    input  logic                              m_ready,
    output logic                              m_valid,
    output logic signed [HEIGHT_W-1:0]        m_height
);

    localparam int NB    = $clog2(GRID_MAX);
    localparam int NW    = $clog2(GRID_MAX + 1);
    localparam int QB    = NB + 16;
    localparam int PW    = COORD_W + NB;
    localparam int RW    = COORD_W;
    localparam int DEPTH = GRID_MAX * GRID_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam int PRW   = NB + NW + 1;
    localparam int MW    = HEIGHT_W + 18;

    function automatic logic [RW:0] div_step(
        input logic [RW-1:0] rem,
        input logic          b,
        input logic [RW-1:0] d
    );
        logic [RW:0] sh;
        logic [RW:0] df;
        sh = {rem, b};
        df = {1'b0, d};
        if (sh >= df) begin
            return {1'b1, RW'(sh - df)};
        end else begin
            return {1'b0, sh[RW-1:0]};
        end
    endfunction

    logic adv;

    // divider pipeline, stage 0 holds the scaled numerators
    meta_t         md_reg [QB+1];
    meta_t         md_next[QB+1];
    logic [RW-1:0] rx_reg [QB+1], rz_reg [QB+1];
    logic [RW-1:0] rx_next[QB+1], rz_next[QB+1];
    logic [QB-1:0] nx_reg [QB+1], nz_reg [QB+1];
    logic [QB-1:0] nx_next[QB+1], nz_next[QB+1];
    logic [QB-1:0] qx_reg [QB+1], qz_reg [QB+1];
    logic [QB-1:0] qx_next[QB+1], qz_next[QB+1];
    logic [PW-1:0] px, pz;
    logic [RW:0]   stx, stz;

    // address stage
    meta_t          ma_reg, ma_next;
    logic [AW-1:0]  a00_reg, a10_reg, a01_reg, a11_reg;
    logic [AW-1:0]  a00_next, a10_next, a01_next, a11_next;
    logic [15:0]    txa_reg, tza_reg, txa_next, tza_next;
    logic [NB-1:0]  x0, x1, z0, z1;
    logic [PRW-1:0] row0, row1;

    // read stage
    meta_t                      mr_reg;
    logic [15:0]                txr_reg, tzr_reg;
    logic [HEIGHT_W-1:0]        rd00, rd10, rd01, rd11;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;

    // blend stages
    meta_t                      ml1_reg, ml2_reg, ml3_reg;
    logic signed [HEIGHT_W-1:0] h00_reg, h01_reg, h0_reg, h1_reg, hb_reg;
    logic signed [HEIGHT_W-1:0] h0_next, h1_next, h_next;
    logic signed [MW-1:0]       p0_reg, p1_reg, p2_reg, p0_next, p1_next, p2_next;
    logic signed [MW-1:0]       r0, r1, r2;
    logic [15:0]                tz1_reg, tz2_reg;
    logic signed [HEIGHT_W:0]   d0, d1, d2;
    logic signed [16:0]         txs, tzs;

    // output register
    logic                       m_valid_reg, m_valid_next;
    logic signed [HEIGHT_W-1:0] m_height_reg, m_height_next;

    // advance the whole back end whenever the output slot is free or drains
    assign adv      = !m_valid_reg || m_ready;
    assign fifo_pop = adv && !fifo_empty;

    always_comb begin
        md_next[0].valid = fifo_pop;
        md_next[0].func  = fifo_item.func;
        md_next[0].idx   = fifo_item.idx;
        md_next[0].wh    = fifo_item.wh;
        px = PW'(fifo_item.a) * PW'(nm1);
        pz = PW'(fifo_item.c) * PW'(nm1);
        rx_next[0] = px[PW-1:NB];
        rz_next[0] = pz[PW-1:NB];
        nx_next[0] = {px[NB-1:0], 16'h0000};
        nz_next[0] = {pz[NB-1:0], 16'h0000};
        qx_next[0] = '0;
        qz_next[0] = '0;
        for (int k = 1; k <= QB; k++) begin
            stx = div_step(rx_reg[k-1], nx_reg[k-1][QB-1], cfg.twice_t);
            stz = div_step(rz_reg[k-1], nz_reg[k-1][QB-1], cfg.twice_t);
            md_next[k] = md_reg[k-1];
            rx_next[k] = stx[RW-1:0];
            rz_next[k] = stz[RW-1:0];
            qx_next[k] = {qx_reg[k-1][QB-2:0], stx[RW]};
            qz_next[k] = {qz_reg[k-1][QB-2:0], stz[RW]};
            nx_next[k] = nx_reg[k-1] << 1;
            nz_next[k] = nz_reg[k-1] << 1;
        end
    end

    // split grid coordinates, clamp the far neighbors, form store addresses
    always_comb begin
        x0 = qx_reg[QB][QB-1:16];
        z0 = qz_reg[QB][QB-1:16];
        x1 = (x0 >= nm1) ? x0 : x0 + 1'b1;
        z1 = (z0 >= nm1) ? z0 : z0 + 1'b1;
        row0 = PRW'(z0) * PRW'(n);
        row1 = PRW'(z1) * PRW'(n);
        ma_next  = md_reg[QB];
        a00_next = AW'(row0 + PRW'(x0));
        a10_next = AW'(row0 + PRW'(x1));
        a01_next = AW'(row1 + PRW'(x0));
        a11_next = AW'(row1 + PRW'(x1));
        txa_next = qx_reg[QB][15:0];
        tza_next = qz_reg[QB][15:0];
    end

    // writes take effect at the store stage, so they keep order with samples
    assign wr_en   = adv && ma_reg.valid && (ma_reg.func == FUNC_WRITE)
                     && (32'(ma_reg.idx) < DEPTH);
    assign wr_addr = AW'(ma_reg.idx);

    hbs_ram #(.WIDTH(HEIGHT_W), .DEPTH(DEPTH)) u_ram00 (
        .aclk(aclk), .we(wr_en), .waddr(wr_addr), .wdata(ma_reg.wh),
        .re(adv), .raddr(a00_reg), .rdata(rd00)
    );
    hbs_ram #(.WIDTH(HEIGHT_W), .DEPTH(DEPTH)) u_ram10 (
        .aclk(aclk), .we(wr_en), .waddr(wr_addr), .wdata(ma_reg.wh),
        .re(adv), .raddr(a10_reg), .rdata(rd10)
    );
    hbs_ram #(.WIDTH(HEIGHT_W), .DEPTH(DEPTH)) u_ram01 (
        .aclk(aclk), .we(wr_en), .waddr(wr_addr), .wdata(ma_reg.wh),
        .re(adv), .raddr(a01_reg), .rdata(rd01)
    );
    hbs_ram #(.WIDTH(HEIGHT_W), .DEPTH(DEPTH)) u_ram11 (
        .aclk(aclk), .we(wr_en), .waddr(wr_addr), .wdata(ma_reg.wh),
        .re(adv), .raddr(a11_reg), .rdata(rd11)
    );

    // blend: weight products, rounding adds with ties toward plus infinity
    always_comb begin
        txs = {1'b0, txr_reg};
        tzs = {1'b0, tz2_reg};
        d0  = (HEIGHT_W+1)'(signed'(rd10)) - (HEIGHT_W+1)'(signed'(rd00));
        d1  = (HEIGHT_W+1)'(signed'(rd11)) - (HEIGHT_W+1)'(signed'(rd01));
        p0_next = MW'(d0) * MW'(txs);
        p1_next = MW'(d1) * MW'(txs);
        r0 = (p0_reg + MW'(32768)) >>> 16;
        r1 = (p1_reg + MW'(32768)) >>> 16;
        h0_next = h00_reg + r0[HEIGHT_W-1:0];
        h1_next = h01_reg + r1[HEIGHT_W-1:0];
        d2  = (HEIGHT_W+1)'(h1_reg) - (HEIGHT_W+1)'(h0_reg);
        p2_next = MW'(d2) * MW'(tzs);
        r2 = (p2_reg + MW'(32768)) >>> 16;
        h_next = hb_reg + r2[HEIGHT_W-1:0];
    end

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_height_next = m_height_reg;
        if (adv) begin
            m_valid_next  = ml3_reg.valid && (ml3_reg.func == FUNC_SAMPLE);
            m_height_next = cfg.res_low ? '0 : h_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= QB; k++) begin
                md_reg[k].valid <= 1'b0;
            end
            ma_reg.valid  <= 1'b0;
            mr_reg.valid  <= 1'b0;
            ml1_reg.valid <= 1'b0;
            ml2_reg.valid <= 1'b0;
            ml3_reg.valid <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (adv) begin
                for (int k = 0; k <= QB; k++) begin
                    md_reg[k] <= md_next[k];
                    rx_reg[k] <= rx_next[k];
                    rz_reg[k] <= rz_next[k];
                    nx_reg[k] <= nx_next[k];
                    nz_reg[k] <= nz_next[k];
                    qx_reg[k] <= qx_next[k];
                    qz_reg[k] <= qz_next[k];
                end
                ma_reg  <= ma_next;
                a00_reg <= a00_next;
                a10_reg <= a10_next;
                a01_reg <= a01_next;
                a11_reg <= a11_next;
                txa_reg <= txa_next;
                tza_reg <= tza_next;
                mr_reg  <= ma_reg;
                txr_reg <= txa_reg;
                tzr_reg <= tza_reg;
                ml1_reg <= mr_reg;
                h00_reg <= signed'(rd00);
                h01_reg <= signed'(rd01);
                p0_reg  <= p0_next;
                p1_reg  <= p1_next;
                tz1_reg <= tzr_reg;
                ml2_reg <= ml1_reg;
                h0_reg  <= h0_next;
                h1_reg  <= h1_next;
                tz2_reg <= tz1_reg;
                ml3_reg <= ml2_reg;
                hb_reg  <= h0_reg;
                p2_reg  <= p2_next;
            end
            m_valid_reg  <= m_valid_next;
            m_height_reg <= m_height_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_height = m_height_reg;

endmodule

@@ src/heightfield_bilinear_sample_core.sv @@
// Top level of the heightfield bilinear sampler: APB registers, front end,
// item queue and back end. Depends on hbs_pkg, hbs_front, hbs_fifo, hbs_back.
//
//  channel  direction  handshake          payload
//  s_       in         s_valid / s_ready  func, write_index, write_height, world_x, world_z
//  m_       out        m_valid / m_ready  height
//  apb      in         psel/penable/pready paddr, pwdata, prdata
//
// One item per cycle sustained while the output is ready. The one-bit-per-stage
// divider scales X and Z to grid units; four replicated height stores serve
// the four corner reads in the same cycle. Write items travel the same pipeline
// and give no item out. Reset clears only control state; the height store is
// not cleared and needs no sweep. A stalled output freezes the whole back end
// while the queue keeps taking items until it fills.
module heightfield_bilinear_sample_core import hbs_pkg::*; #(
    parameter int GRID_MAX = 256
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_func,
    input  logic [INDEX_W-1:0]         s_write_index,
    input  logic signed [HEIGHT_W-1:0] s_write_height,
    input  logic signed [HEIGHT_W-1:0] s_world_x,
    input  logic signed [HEIGHT_W-1:0] s_world_z,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [HEIGHT_W-1:0] m_height,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int NB = $clog2(GRID_MAX);
    localparam int NW = $clog2(GRID_MAX + 1);

    logic [SIZE_W-1:0] size_reg, size_next;
    logic [RES_W-1:0]  res_reg, res_next;
    logic              cfg_wr;
    cfg_t              cfg;
    logic [NW-1:0]     n;
    logic [NB-1:0]     nm1;
    logic              fifo_full, fifo_empty, fifo_push, fifo_pop;
    item_t             push_item, head_item;

    // register file: word address selects the register, low bits are ignored
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_GRID_RES) ? {23'd0, res_reg} : {8'd0, size_reg};

    always_comb begin
        size_next = size_reg;
        res_next  = res_reg;
        if (cfg_wr) begin
            if (paddr[2] == REG_TERRAIN_SIZE) begin
                size_next = pwdata[SIZE_W-1:0];
            end else begin
                res_next = pwdata[RES_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_RST;
            res_reg  <= RES_RST;
        end else begin
            size_reg <= size_next;
            res_reg  <= res_next;
        end
    end

    // derived settings: terrain size floored at 1.0, resolution capped
    always_comb begin
        cfg.t       = (size_reg < SIZE_ONE) ? SIZE_ONE : size_reg;
        cfg.twice_t = {cfg.t, 1'b0};
        cfg.res_low = (res_reg < RES_MIN);
        n   = (32'(res_reg) > GRID_MAX) ? NW'(GRID_MAX) : NW'(res_reg);
        nm1 = NB'(n - 1'b1);
    end

    hbs_front u_front (
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_write_index(s_write_index), .s_write_height(s_write_height),
        .s_world_x(s_world_x), .s_world_z(s_world_z), .cfg(cfg),
        .fifo_full(fifo_full), .push(fifo_push), .push_item(push_item)
    );

    hbs_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn), .push(fifo_push), .push_item(push_item),
        .pop(fifo_pop), .head_item(head_item), .full(fifo_full), .empty(fifo_empty)
    );

    hbs_back #(.GRID_MAX(GRID_MAX)) u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg), .n(n), .nm1(nm1),
        .fifo_empty(fifo_empty), .fifo_item(head_item), .fifo_pop(fifo_pop),
        .m_ready(m_ready), .m_valid(m_valid), .m_height(m_height)
    );

endmodule
